// ===== design/tlex_pkg.sv =====
`timescale 1ns / 1ps

package tlex_pkg;

  // Width of byte offsets and token lengths; both saturate at the top value.
  localparam int POS_W = 16;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Only the first bytes of a word are kept for the keyword compare.
  localparam int PREFIX_BYTES = 5;
  localparam int PREFIX_W = 8 * PREFIX_BYTES;

  // Depth of the queue between the scanner and the output stage.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Keyword text packed first byte lowest.
  localparam logic [PREFIX_W-1:0] KW_TXT_IF    = 40'h0000006669;
  localparam logic [PREFIX_W-1:0] KW_TXT_MAIN  = 40'h006e69616d;
  localparam logic [PREFIX_W-1:0] KW_TXT_ELSE  = 40'h0065736c65;
  localparam logic [PREFIX_W-1:0] KW_TXT_FOR   = 40'h0000726f66;
  localparam logic [PREFIX_W-1:0] KW_TXT_WHILE = 40'h656c696877;
  localparam logic [PREFIX_W-1:0] KW_TXT_INT   = 40'h0000746e69;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_NUMBER = 2'd1,
    MODE_WORD   = 2'd2,
    MODE_OPER   = 2'd3
  } scan_mode_e;

  typedef enum logic [2:0] {
    KIND_INT      = 3'd0,
    KIND_KEYWORD  = 3'd1,
    KIND_IDENT    = 3'd2,
    KIND_BOUNDARY = 3'd3,
    KIND_OPER     = 3'd4
  } tok_kind_e;

  typedef enum logic [2:0] {
    KW_IF    = 3'd0,
    KW_MAIN  = 3'd1,
    KW_ELSE  = 3'd2,
    KW_FOR   = 3'd3,
    KW_WHILE = 3'd4,
    KW_INT   = 3'd5
  } kw_code_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    tok_kind_e        token_kind;
    kw_code_e         keyword_code;
    logic [POS_W-1:0] start_position;
    logic [POS_W-1:0] token_length;
    logic [7:0]       first_char;
    logic [7:0]       second_char;
    logic             last_of_run;
  } out_item_t;

  // All tokens caused by one source byte; tok1 is used only when two is set.
  typedef struct packed {
    logic      two;
    out_item_t tok0;
    out_item_t tok1;
  } lex_run_t;

  typedef struct packed {
    logic     hit;
    kw_code_e code;
  } kw_hit_t;

endpackage

// ===== design/toy_c_lexer_tokenizer_top.sv =====
`timescale 1ns / 1ps

// Streaming tokenizer for a small C subset.
// The in_ channel carries one source byte per beat with an end-of-text flag.
// The out_ channel carries one token descriptor per beat; last_of_run marks
// the last token caused by a given byte, and a byte may cause none, one or two.
// A scanner accepts one byte per cycle while the queue is not full and writes
// the tokens of each byte as one entry into a four-entry queue; an output stage
// drains the queue one token per cycle, while the receiver is ready, through a
// registered output. A token that a byte closes is written into the queue and
// then into the output register before it appears on out_valid.
// Throughput: one byte per cycle as long as bytes cause at most one token
// each; the single output port bounds the sustained rate to one token per
// cycle, so a byte that causes two tokens keeps its entry until both are sent.
// When the receiver stalls, the queue fills and in_ready drops once it is
// full; no token is lost. Reset clears the scanner state, empties the queue
// and drops out_valid; position counting restarts at offset zero, as it also
// does after each end-of-text byte.

module toy_c_lexer_tokenizer_top import tlex_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic     q_push, q_pop, q_full, q_empty;
  lex_run_t q_wr_data, q_rd_data;

  // Scanner.
  tlex_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wr_data)
  );

  // Decoupling queue.
  tlex_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .empty     (q_empty)
  );

  // Output stage.
  tlex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/tlex_front.sv =====
`timescale 1ns / 1ps

module tlex_front import tlex_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  input  logic     q_full,
  output logic     q_push,
  output lex_run_t q_data
);

  // Scanner state.
  scan_mode_e          mode_r, mode_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    start_r, start_nxt;
  logic [POS_W-1:0]    len_r, len_nxt;
  logic [PREFIX_W-1:0] prefix_r, prefix_nxt;
  logic [7:0]          pend_r, pend_nxt;

  logic accept;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_boundary(input logic [7:0] c);
    return (c == "{") || (c == "}") || (c == "(") || (c == ")") || (c == ",") || (c == ";");
  endfunction

  function automatic logic is_operator(input logic [7:0] c);
    return (c == "=") || (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
           (c == "<") || (c == ">") || (c == "!");
  endfunction

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  // A saturated length never equals a keyword length, so long words miss.
  function automatic kw_hit_t kw_lookup(input logic [PREFIX_W-1:0] pre,
                                        input logic [POS_W-1:0] len);
    kw_hit_t r;
    r.hit  = 1'b1;
    r.code = KW_IF;
    priority if (len == POS_W'(2) && pre == KW_TXT_IF) begin
      r.code = KW_IF;
    end else if (len == POS_W'(4) && pre == KW_TXT_MAIN) begin
      r.code = KW_MAIN;
    end else if (len == POS_W'(4) && pre == KW_TXT_ELSE) begin
      r.code = KW_ELSE;
    end else if (len == POS_W'(3) && pre == KW_TXT_FOR) begin
      r.code = KW_FOR;
    end else if (len == POS_W'(5) && pre == KW_TXT_WHILE) begin
      r.code = KW_WHILE;
    end else if (len == POS_W'(3) && pre == KW_TXT_INT) begin
      r.code = KW_INT;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // Descriptor of the token pending in the given state.
  function automatic out_item_t flush_tok(input scan_mode_e m,
                                          input logic [POS_W-1:0] st,
                                          input logic [POS_W-1:0] ln,
                                          input logic [PREFIX_W-1:0] pre,
                                          input logic [7:0] op);
    out_item_t t;
    kw_hit_t   k;
    t = '0;
    k = kw_lookup(pre, ln);
    t.start_position = st;
    t.token_length   = ln;
    unique case (m)
      MODE_NUMBER: t.token_kind = KIND_INT;
      MODE_WORD: begin
        if (k.hit) begin
          t.token_kind   = KIND_KEYWORD;
          t.keyword_code = k.code;
        end else begin
          t.token_kind = KIND_IDENT;
        end
      end
      MODE_OPER: begin
        t.token_kind   = KIND_OPER;
        t.token_length = POS_W'(1);
        t.first_char   = op;
      end
      MODE_IDLE: t = '0;
    endcase
    return t;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Next state and the tokens caused by the offered byte.
  always_comb begin
    logic [7:0]          c;
    logic                keep;
    logic                fresh;
    logic                has_a, has_b, has_c;
    out_item_t           tok_a, tok_b, tok_c;
    scan_mode_e          mode1;
    logic [POS_W-1:0]    start1, len1;
    logic [PREFIX_W-1:0] pre1;
    logic [7:0]          pend1;
    logic [5:0]          bit_ix;

    c      = in_data.char_byte;
    keep   = 1'b0;
    fresh  = 1'b1;
    has_a  = 1'b0;
    has_b  = 1'b0;
    has_c  = 1'b0;
    tok_a  = '0;
    tok_b  = '0;
    tok_c  = '0;
    mode1  = mode_r;
    start1 = start_r;
    len1   = len_r;
    pre1   = prefix_r;
    pend1  = pend_r;
    bit_ix = {len_r[2:0], 3'b000};

    // Extend the pending run, or close it.
    unique case (mode_r)
      MODE_NUMBER: begin
        if (is_digit(c)) begin
          len1 = sat_inc(len_r);
          keep = 1'b1;
        end else begin
          tok_a = flush_tok(mode_r, start_r, len_r, prefix_r, pend_r);
          has_a = 1'b1;
        end
      end
      MODE_WORD: begin
        if (is_alpha(c) || is_digit(c) || (c == "_")) begin
          if (len_r < POS_W'(PREFIX_BYTES)) begin
            pre1[bit_ix +: 8] = c;
          end
          len1 = sat_inc(len_r);
          keep = 1'b1;
        end else begin
          tok_a = flush_tok(mode_r, start_r, len_r, prefix_r, pend_r);
          has_a = 1'b1;
        end
      end
      MODE_OPER: begin
        has_a = 1'b1;
        if ((c == "=") && ((pend_r == "=") || (pend_r == ">") ||
                           (pend_r == "<") || (pend_r == "!"))) begin
          tok_a                = '0;
          tok_a.token_kind     = KIND_OPER;
          tok_a.start_position = start_r;
          tok_a.token_length   = POS_W'(2);
          tok_a.first_char     = pend_r;
          tok_a.second_char    = c;
          fresh                = 1'b0;
        end else begin
          tok_a = flush_tok(mode_r, start_r, len_r, prefix_r, pend_r);
        end
      end
      MODE_IDLE: ;
    endcase

    if (!keep) begin
      mode1  = MODE_IDLE;
      start1 = '0;
      len1   = '0;
      pre1   = '0;
      pend1  = '0;
    end else begin
      fresh = 1'b0;
    end

    // Start a new token at this byte.
    if (fresh) begin
      priority if (is_digit(c)) begin
        mode1  = MODE_NUMBER;
        start1 = pos_r;
        len1   = POS_W'(1);
      end else if (is_alpha(c) || (c == "_")) begin
        mode1  = MODE_WORD;
        start1 = pos_r;
        len1   = POS_W'(1);
        pre1   = PREFIX_W'(c);
      end else if (is_boundary(c)) begin
        has_b                = 1'b1;
        tok_b.token_kind     = KIND_BOUNDARY;
        tok_b.start_position = pos_r;
        tok_b.token_length   = POS_W'(1);
        tok_b.first_char     = c;
      end else if (is_operator(c)) begin
        mode1  = MODE_OPER;
        start1 = pos_r;
        len1   = POS_W'(1);
        pend1  = c;
      end else begin
        // Space, newline and every other byte start nothing.
      end
    end

    mode_nxt   = mode1;
    start_nxt  = start1;
    len_nxt    = len1;
    prefix_nxt = pre1;
    pend_nxt   = pend1;
    pos_nxt    = sat_inc(pos_r);

    // End of text flushes whatever is still pending and rewinds the offset.
    if (in_data.end_of_text) begin
      has_c      = (mode1 != MODE_IDLE);
      tok_c      = flush_tok(mode1, start1, len1, pre1, pend1);
      mode_nxt   = MODE_IDLE;
      start_nxt  = '0;
      len_nxt    = '0;
      prefix_nxt = '0;
      pend_nxt   = '0;
      pos_nxt    = '0;
    end

    // Pack the tokens in order into the queue entry.
    q_data.two  = (has_a && (has_b || has_c)) || (has_b && has_c);
    q_data.tok0 = has_a ? tok_a : (has_b ? tok_b : tok_c);
    q_data.tok1 = (has_a && has_b) ? tok_b : tok_c;
    q_data.tok0.last_of_run = !q_data.two;
    q_data.tok1.last_of_run = 1'b1;
    q_push = accept && (has_a || has_b || has_c);
  end

  // State advances only on an accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      pos_r    <= '0;
      start_r  <= '0;
      len_r    <= '0;
      prefix_r <= '0;
      pend_r   <= '0;
    end else if (accept) begin
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
      len_r    <= len_nxt;
      prefix_r <= prefix_nxt;
      pend_r   <= pend_nxt;
    end
  end

endmodule

// ===== design/tlex_queue.sv =====
`timescale 1ns / 1ps

module tlex_queue import tlex_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  lex_run_t push_data,
  output logic     full,
  input  logic     pop,
  output lex_run_t pop_data,
  output logic     empty
);

  lex_run_t            entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/tlex_back.sv =====
`timescale 1ns / 1ps

module tlex_back import tlex_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  lex_run_t  q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      sel_r, sel_nxt;
  logic      load;

  // The output register takes a queued token whenever it is empty or being drained.
  assign load  = (!out_valid_r || out_ready) && !q_empty;
  assign q_pop = load && (sel_r || !q_data.two);

  always_comb begin
    sel_nxt = sel_r;
    if (load) begin
      sel_nxt = !q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Serialize the one or two tokens of a queue entry.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= sel_r ? q_data.tok1 : q_data.tok0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/tlex_checker.sv =====
`timescale 1ns / 1ps

module tlex_checker import tlex_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled token holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output token changed while stalled");

  // Reset empties the output and the queue.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("output valid or input blocked right after reset");

  // Every token has at least one byte.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.token_length != '0)
    else $error("token of zero length");

  // Only keywords carry a keyword code.
  a_kw_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.token_kind != KIND_KEYWORD |-> out_data.keyword_code == KW_IF)
    else $error("keyword code on a token that is no keyword");

  // Runs of digits or letters carry no characters.
  a_run_chars: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.token_kind == KIND_INT || out_data.token_kind == KIND_KEYWORD ||
                  out_data.token_kind == KIND_IDENT)
    |-> out_data.first_char == 8'h00 && out_data.second_char == 8'h00)
    else $error("characters on a run token");

endmodule

bind toy_c_lexer_tokenizer_top tlex_checker u_tlex_checker (.*);
